FILE: src/vvps_pkg.sv
`timescale 1ns / 1ps

package vvps_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_TIME_STEP  = 2'd0;
	localparam logic [1:0] REG_BOX_WIDTH  = 2'd1;
	localparam logic [1:0] REG_BOX_HEIGHT = 2'd2;

	// action codes
	localparam logic ACT_MOVE = 1'b0;
	localparam logic ACT_KICK = 1'b1;

	// reset values of the configuration registers
	localparam logic [15:0] TIME_STEP_RST = 16'd328;
	localparam logic [31:0] DT_SQ_RST     = 32'd107584;
	localparam logic [30:0] BOX_RST       = 31'd655360;

	// product widths: v*dt, f*dt^2, (fo+fn)*dt
	localparam int PV_W = 49;
	localparam int PF_W = 65;
	localparam int PK_W = 50;
	// one guard bit for the rounding add
	localparam int RV_W = PV_W + 1;
	localparam int RF_W = PF_W + 1;
	localparam int RK_W = PK_W + 1;
	// exact width of an axis sum before saturation
	localparam int SUM_W = 50;

	typedef struct packed {
		logic en_s2;
		logic en_s3;
		logic en_s4;
		logic en_s5;
	} vvps_stage_en_t;

	typedef struct packed {
		logic signed [31:0] pos_new;
		logic signed [31:0] vel_new;
		logic signed [31:0] pos_old;
		logic signed [31:0] vel_old;
	} vvps_lane_res_t;

	// clamp an exact sum to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
		logic signed [31:0] r;
		if (v[SUM_W-1:31] == {(SUM_W-31){1'b0}} || v[SUM_W-1:31] == {(SUM_W-31){1'b1}}) begin
			r = v[31:0];
		end else if (v[SUM_W-1]) begin
			r = {1'b1, 31'd0};
		end else begin
			r = {1'b0, {31{1'b1}}};
		end
		return r;
	endfunction

endpackage

FILE: src/velocity_verlet_particle_step_top.sv
`timescale 1ns / 1ps
// Pipeline: five register stages from input acceptance to out_valid
// (capture, multiply, round and sum, wrap and saturate, merge).
// One item per cycle while out_ready holds; each lane owns three multipliers.
// Reset: arst_n clears all stage valid bits and loads time_step = 328 and
// both box lengths = 655360; datapath registers are not reset.
module velocity_verlet_particle_step_top #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration write port
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [30:0]        cfg_data,
	// input channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               action,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] vel_x,
	input  logic signed [31:0] vel_y,
	input  logic signed [31:0] force_old_x,
	input  logic signed [31:0] force_old_y,
	input  logic signed [31:0] force_new_x,
	input  logic signed [31:0] force_new_y,
	input  logic               last_particle,
	// output channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] pos_x_out,
	output logic signed [31:0] pos_y_out,
	output logic signed [31:0] vel_x_out,
	output logic signed [31:0] vel_y_out,
	output logic               last_out
);

	// configuration registers; dt^2 is registered from time_step in the cycle after
	logic [15:0] time_step_q;
	logic [31:0] dt_sq_q;
	logic [30:0] box_width_q;
	logic [30:0] box_height_q;

	// stage valid bits and per-stage ready
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;

	vvps_pkg::vvps_stage_en_t en;

	// input capture stage
	logic               action_s1;
	logic               last_s1;
	logic signed [31:0] pos_x_s1;
	logic signed [31:0] pos_y_s1;
	logic signed [31:0] vel_x_s1;
	logic signed [31:0] vel_y_s1;
	logic signed [31:0] force_old_x_s1;
	logic signed [31:0] force_old_y_s1;
	logic signed [32:0] force_sum_x_s1;
	logic signed [32:0] force_sum_y_s1;

	// sideband that rides alongside the lanes
	logic action_s2, action_s3, action_s4;
	logic last_s2, last_s3, last_s4;

	vvps_pkg::vvps_lane_res_t res_x;
	vvps_pkg::vvps_lane_res_t res_y;

	// Configuration writes. Index values past the register list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q  <= vvps_pkg::TIME_STEP_RST;
			box_width_q  <= vvps_pkg::BOX_RST;
			box_height_q <= vvps_pkg::BOX_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				vvps_pkg::REG_TIME_STEP:  time_step_q  <= cfg_data[15:0];
				vvps_pkg::REG_BOX_WIDTH:  box_width_q  <= cfg_data;
				vvps_pkg::REG_BOX_HEIGHT: box_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Square the step once here so the lanes only see a ready-made dt^2.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_sq_q <= vvps_pkg::DT_SQ_RST;
		end else begin
			dt_sq_q <= time_step_q * time_step_q;
		end
	end

	// A stage takes a new item when it is empty or its item moves on, so bubbles
	// collapse; a waiting result blocks the input only when every stage is full.
	assign rdy_s5 = !vld_s5 || out_ready;
	assign rdy_s4 = !vld_s4 || rdy_s5;
	assign rdy_s3 = !vld_s3 || rdy_s4;
	assign rdy_s2 = !vld_s2 || rdy_s3;
	assign rdy_s1 = !vld_s1 || rdy_s2;

	assign in_ready  = rdy_s1;
	assign out_valid = vld_s5;

	assign en.en_s2 = rdy_s2;
	assign en.en_s3 = rdy_s3;
	assign en.en_s4 = rdy_s4;
	assign en.en_s5 = rdy_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= in_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
			if (rdy_s5) vld_s5 <= vld_s4;
		end
	end

	// Capture the item; the kick needs only fo + fn, so add it on the way in.
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			action_s1      <= action;
			last_s1        <= last_particle;
			pos_x_s1       <= pos_x;
			pos_y_s1       <= pos_y;
			vel_x_s1       <= vel_x;
			vel_y_s1       <= vel_y;
			force_old_x_s1 <= force_old_x;
			force_old_y_s1 <= force_old_y;
			force_sum_x_s1 <= 33'(force_old_x) + 33'(force_new_x);
			force_sum_y_s1 <= 33'(force_old_y) + 33'(force_new_y);
		end
	end

	// Hold action and the sweep marker in step with the lane stages.
	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			action_s2 <= action_s1;
			last_s2   <= last_s1;
		end
		if (rdy_s3) begin
			action_s3 <= action_s2;
			last_s3   <= last_s2;
		end
		if (rdy_s4) begin
			action_s4 <= action_s3;
			last_s4   <= last_s3;
		end
	end

	// One lane per axis; each computes both the move and the kick.
	vvps_lane #(
		.FRAC_BITS (FRAC_BITS)
	) u_lane_x (
		.clk       (clk),
		.en        (en),
		.time_step (time_step_q),
		.dt_sq     (dt_sq_q),
		.box       (box_width_q),
		.pos       (pos_x_s1),
		.vel       (vel_x_s1),
		.force_old (force_old_x_s1),
		.force_sum (force_sum_x_s1),
		.res       (res_x)
	);

	vvps_lane #(
		.FRAC_BITS (FRAC_BITS)
	) u_lane_y (
		.clk       (clk),
		.en        (en),
		.time_step (time_step_q),
		.dt_sq     (dt_sq_q),
		.box       (box_height_q),
		.pos       (pos_y_s1),
		.vel       (vel_y_s1),
		.force_old (force_old_y_s1),
		.force_sum (force_sum_y_s1),
		.res       (res_y)
	);

	// Merge both lanes into the output register, selecting by action.
	vvps_merge u_merge (
		.clk       (clk),
		.en        (en),
		.action    (action_s4),
		.last      (last_s4),
		.res_x     (res_x),
		.res_y     (res_y),
		.pos_x_out (pos_x_out),
		.pos_y_out (pos_y_out),
		.vel_x_out (vel_x_out),
		.vel_y_out (vel_y_out),
		.last_out  (last_out)
	);

endmodule

FILE: src/vvps_lane.sv
`timescale 1ns / 1ps

module vvps_lane #(
	parameter int FRAC_BITS = 16
) (
	input  logic                     clk,
	input  vvps_pkg::vvps_stage_en_t en,
	input  logic [15:0]              time_step,
	input  logic [31:0]              dt_sq,
	input  logic [30:0]              box,
	input  logic signed [31:0]       pos,
	input  logic signed [31:0]       vel,
	input  logic signed [31:0]       force_old,
	input  logic signed [32:0]       force_sum,
	output vvps_pkg::vvps_lane_res_t res
);

	localparam logic signed [vvps_pkg::RV_W-1:0] HALF_V =
		vvps_pkg::RV_W'(1) << (FRAC_BITS - 1);
	localparam logic signed [vvps_pkg::RF_W-1:0] HALF_F =
		vvps_pkg::RF_W'(1) << (2 * FRAC_BITS);
	localparam logic signed [vvps_pkg::RK_W-1:0] HALF_K =
		vvps_pkg::RK_W'(1) << FRAC_BITS;

	logic signed [16:0] dt_s;
	logic signed [32:0] dt_sq_s;

	logic signed [vvps_pkg::PV_W-1:0] prod_v_s2;
	logic signed [vvps_pkg::PF_W-1:0] prod_f_s2;
	logic signed [vvps_pkg::PK_W-1:0] prod_k_s2;
	logic signed [31:0]               pos_s2;
	logic signed [31:0]               vel_s2;

	logic signed [vvps_pkg::RV_W-1:0] rnd_v;
	logic signed [vvps_pkg::RF_W-1:0] rnd_f;
	logic signed [vvps_pkg::RK_W-1:0] rnd_k;

	logic signed [vvps_pkg::SUM_W-1:0] move_sum_s3;
	logic signed [vvps_pkg::SUM_W-1:0] kick_sum_s3;
	logic signed [31:0]                pos_s3;
	logic signed [31:0]                vel_s3;

	logic signed [vvps_pkg::SUM_W-1:0] box_s;
	logic signed [vvps_pkg::SUM_W-1:0] wrapped;

	vvps_pkg::vvps_lane_res_t res_s4;

	assign dt_s    = {1'b0, time_step};
	assign dt_sq_s = {1'b0, dt_sq};

	// multiply
	always_ff @(posedge clk) begin
		if (en.en_s2) begin
			prod_v_s2 <= vel * dt_s;
			prod_f_s2 <= force_old * dt_sq_s;
			prod_k_s2 <= force_sum * dt_s;
			pos_s2    <= pos;
			vel_s2    <= vel;
		end
	end

	// round each term to nearest, ties up
	always_comb begin
		rnd_v = (vvps_pkg::RV_W'(prod_v_s2) + HALF_V) >>> FRAC_BITS;
		rnd_f = (vvps_pkg::RF_W'(prod_f_s2) + HALF_F) >>> (2 * FRAC_BITS + 1);
		rnd_k = (vvps_pkg::RK_W'(prod_k_s2) + HALF_K) >>> (FRAC_BITS + 1);
	end

	always_ff @(posedge clk) begin
		if (en.en_s3) begin
			move_sum_s3 <= vvps_pkg::SUM_W'(pos_s2) + vvps_pkg::SUM_W'(rnd_v)
				+ vvps_pkg::SUM_W'(rnd_f);
			kick_sum_s3 <= vvps_pkg::SUM_W'(vel_s2) + vvps_pkg::SUM_W'(rnd_k);
			pos_s3      <= pos_s2;
			vel_s3      <= vel_s2;
		end
	end

	// one periodic correction, upper test first
	assign box_s = $signed(vvps_pkg::SUM_W'(box));

	always_comb begin
		if (move_sum_s3 >= box_s) begin
			wrapped = move_sum_s3 - box_s;
		end else if (move_sum_s3[vvps_pkg::SUM_W-1]) begin
			wrapped = move_sum_s3 + box_s;
		end else begin
			wrapped = move_sum_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en.en_s4) begin
			res_s4.pos_new <= vvps_pkg::sat32(wrapped);
			res_s4.vel_new <= vvps_pkg::sat32(kick_sum_s3);
			res_s4.pos_old <= pos_s3;
			res_s4.vel_old <= vel_s3;
		end
	end

	assign res = res_s4;

endmodule

FILE: src/vvps_merge.sv
`timescale 1ns / 1ps

module vvps_merge (
	input  logic                     clk,
	input  vvps_pkg::vvps_stage_en_t en,
	input  logic                     action,
	input  logic                     last,
	input  vvps_pkg::vvps_lane_res_t res_x,
	input  vvps_pkg::vvps_lane_res_t res_y,
	output logic signed [31:0]       pos_x_out,
	output logic signed [31:0]       pos_y_out,
	output logic signed [31:0]       vel_x_out,
	output logic signed [31:0]       vel_y_out,
	output logic                     last_out
);

	logic signed [31:0] pos_x_s5;
	logic signed [31:0] pos_y_s5;
	logic signed [31:0] vel_x_s5;
	logic signed [31:0] vel_y_s5;
	logic               last_s5;

	// pick the updated pair by action, pass the other pair through
	always_ff @(posedge clk) begin
		if (en.en_s5) begin
			last_s5 <= last;
			case (action)
				vvps_pkg::ACT_KICK: begin
					pos_x_s5 <= res_x.pos_old;
					pos_y_s5 <= res_y.pos_old;
					vel_x_s5 <= res_x.vel_new;
					vel_y_s5 <= res_y.vel_new;
				end
				default: begin
					pos_x_s5 <= res_x.pos_new;
					pos_y_s5 <= res_y.pos_new;
					vel_x_s5 <= res_x.vel_old;
					vel_y_s5 <= res_y.vel_old;
				end
			endcase
		end
	end

	assign pos_x_out = pos_x_s5;
	assign pos_y_out = pos_y_s5;
	assign vel_x_out = vel_x_s5;
	assign vel_y_out = vel_y_s5;
	assign last_out  = last_s5;

endmodule

FILE: tb/sv/particle_step_checker.sv
`timescale 1ns / 1ps

module particle_step_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [30:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               action,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] vel_x,
	input  logic signed [31:0] vel_y,
	input  logic signed [31:0] force_old_x,
	input  logic signed [31:0] force_old_y,
	input  logic signed [31:0] force_new_x,
	input  logic signed [31:0] force_new_y,
	input  logic               last_particle,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [31:0] pos_x_out,
	input  logic signed [31:0] pos_y_out,
	input  logic signed [31:0] vel_x_out,
	input  logic signed [31:0] vel_y_out,
	input  logic               last_out,
	output int                 mismatch_count,
	output int                 results_owed
);

	localparam int FB = 16;

	typedef logic signed [79:0] wide_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic               last;
	} stepped_t;

	localparam wide_t WIDE_MAX = 80'sd2147483647;
	localparam wide_t WIDE_MIN = -80'sd2147483648;

	logic [15:0] step_dt;
	logic [30:0] box_x;
	logic [30:0] box_y;
	stepped_t    stepped_particles[$];
	int          errors = 0;

	// nearest, ties toward plus infinity
	function automatic wide_t round_nearest(input wide_t v, input int sh);
		wide_t half;
		half = 1;
		half = half <<< (sh - 1);
		return (v + half) >>> sh;
	endfunction

	function automatic logic signed [31:0] clamp32(input wide_t v);
		if (v > WIDE_MAX)
			return 32'sh7fffffff;
		if (v < WIDE_MIN)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] drift(input logic signed [31:0] p, v, f,
			input logic [30:0] box);
		wide_t pw, vw, fw, dtw, bw, sum;
		pw  = p;
		vw  = v;
		fw  = f;
		dtw = step_dt;
		bw  = box;
		sum = pw + round_nearest(vw * dtw, FB) + round_nearest(fw * dtw * dtw, 2 * FB + 1);
		// one correction only
		if (sum >= bw)
			sum = sum - bw;
		else if (sum < 0)
			sum = sum + bw;
		return clamp32(sum);
	endfunction

	function automatic logic signed [31:0] kick(input logic signed [31:0] v, fo, fn);
		wide_t vw, fsum, dtw;
		vw   = v;
		fsum = fo;
		fsum = fsum + fn;
		dtw  = step_dt;
		return clamp32(vw + round_nearest(fsum * dtw, FB + 1));
	endfunction

	function automatic stepped_t verlet_step();
		stepped_t r;
		r.pos_x = pos_x;
		r.pos_y = pos_y;
		r.vel_x = vel_x;
		r.vel_y = vel_y;
		r.last  = last_particle;
		if (action == vvps_pkg::ACT_KICK) begin
			r.vel_x = kick(vel_x, force_old_x, force_new_x);
			r.vel_y = kick(vel_y, force_old_y, force_new_y);
		end else begin
			r.pos_x = drift(pos_x, vel_x, force_old_x, box_x);
			r.pos_y = drift(pos_y, vel_y, force_old_y, box_y);
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic signed [31:0] want, got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		stepped_t want;
		if (!arst_n) begin
			step_dt <= vvps_pkg::TIME_STEP_RST;
			box_x <= vvps_pkg::BOX_RST;
			box_y <= vvps_pkg::BOX_RST;
			stepped_particles.delete();
			results_owed <= 0;
			mismatch_count <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (stepped_particles.size() == 0) begin
					$error("unexpected item: pos_x_out %0d, pos_y_out %0d",
						pos_x_out, pos_y_out);
					errors++;
				end else begin
					want = stepped_particles.pop_front();
					check_field("pos_x_out", want.pos_x, pos_x_out);
					check_field("pos_y_out", want.pos_y, pos_y_out);
					check_field("vel_x_out", want.vel_x, vel_x_out);
					check_field("vel_y_out", want.vel_y, vel_y_out);
					check_field("last_out", {31'd0, want.last}, {31'd0, last_out});
				end
			end
			if (in_valid && in_ready)
				stepped_particles.push_back(verlet_step());
			if (cfg_write) begin
				case (cfg_index)
					vvps_pkg::REG_TIME_STEP:  step_dt <= cfg_data[15:0];
					vvps_pkg::REG_BOX_WIDTH:  box_x <= cfg_data;
					vvps_pkg::REG_BOX_HEIGHT: box_y <= cfg_data;
					default: ;
				endcase
			end
			results_owed <= stepped_particles.size();
			mismatch_count <= errors;
		end
	end

endmodule

FILE: tb/sv/tb_velocity_verlet_particle_step_top.sv
`timescale 1ns / 1ps

module tb_velocity_verlet_particle_step_top;

	// generous bound for ~1200 items under heavy stalls
	localparam int CYCLE_LIMIT = 400000;
	localparam int ITEMS_PER_PHASE = 150;
	localparam int NUM_PHASES = 8;

	typedef struct packed {
		logic               action;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] fox;
		logic signed [31:0] foy;
		logic signed [31:0] fnx;
		logic signed [31:0] fny;
		logic               last;
	} particle_in_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_write = 1'b0;
	logic [1:0]         cfg_index = vvps_pkg::REG_TIME_STEP;
	logic [30:0]        cfg_data = 31'd0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               action = vvps_pkg::ACT_MOVE;
	logic signed [31:0] pos_x = 32'sd0;
	logic signed [31:0] pos_y = 32'sd0;
	logic signed [31:0] vel_x = 32'sd0;
	logic signed [31:0] vel_y = 32'sd0;
	logic signed [31:0] force_old_x = 32'sd0;
	logic signed [31:0] force_old_y = 32'sd0;
	logic signed [31:0] force_new_x = 32'sd0;
	logic signed [31:0] force_new_y = 32'sd0;
	logic               last_particle = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] pos_x_out;
	logic signed [31:0] pos_y_out;
	logic signed [31:0] vel_x_out;
	logic signed [31:0] vel_y_out;
	logic               last_out;

	int          mismatch_count;
	int          results_owed;
	int          cycle_count = 0;
	int          idle_pct = 0;	// chance in 100, per draw, that the sender holds valid low
	int          stall_pct = 0;	// chance in 100 that the receiver drops ready
	logic [30:0] box_w_now = vvps_pkg::BOX_RST;
	logic [30:0] box_h_now = vvps_pkg::BOX_RST;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	velocity_verlet_particle_step_top DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .action(action),
		.pos_x(pos_x), .pos_y(pos_y), .vel_x(vel_x), .vel_y(vel_y),
		.force_old_x(force_old_x), .force_old_y(force_old_y),
		.force_new_x(force_new_x), .force_new_y(force_new_y),
		.last_particle(last_particle),
		.out_valid(out_valid), .out_ready(out_ready),
		.pos_x_out(pos_x_out), .pos_y_out(pos_y_out),
		.vel_x_out(vel_x_out), .vel_y_out(vel_y_out), .last_out(last_out)
	);

	particle_step_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .action(action),
		.pos_x(pos_x), .pos_y(pos_y), .vel_x(vel_x), .vel_y(vel_y),
		.force_old_x(force_old_x), .force_old_y(force_old_y),
		.force_new_x(force_new_x), .force_new_y(force_new_y),
		.last_particle(last_particle),
		.out_valid(out_valid), .out_ready(out_ready),
		.pos_x_out(pos_x_out), .pos_y_out(pos_y_out),
		.vel_x_out(vel_x_out), .vel_y_out(vel_y_out), .last_out(last_out),
		.mismatch_count(mismatch_count), .results_owed(results_owed)
	);

	// Receiver: redraw ready every cycle from the current stall rate.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Watchdog: abort a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic particle_in_t make_particle(input logic act,
			input logic signed [31:0] px, py, vx, vy, fox, foy, fnx, fny,
			input logic last);
		particle_in_t p;
		p.action = act;
		p.px = px;
		p.py = py;
		p.vx = vx;
		p.vy = vy;
		p.fox = fox;
		p.foy = foy;
		p.fnx = fnx;
		p.fny = fny;
		p.last = last;
		return p;
	endfunction

	// Random magnitude: arithmetic shift spreads values over every scale, both signs.
	function automatic logic signed [31:0] spread_value();
		int v;
		v = $urandom;
		return v >>> $urandom_range(31, 0);
	endfunction

	function automatic logic signed [31:0] box_position(input logic [30:0] box);
		logic signed [31:0] p;
		case ($urandom_range(3))
			0: p = $urandom_range(255);		// hug the low wall
			1: p = box - 1 - $urandom_range(255);	// hug the high wall
			default: p = $urandom_range(box - 1, 0);
		endcase
		return p;
	endfunction

	// Mostly physical particles inside the box; the rest full-range noise.
	function automatic particle_in_t random_particle();
		particle_in_t p;
		p.action = 1'($urandom_range(1));
		p.last = ($urandom_range(7) == 0);
		if ($urandom_range(99) < 70) begin
			p.px = box_position(box_w_now);
			p.py = box_position(box_h_now);
			p.vx = spread_value();
			p.vy = spread_value();
			p.fox = spread_value();
			p.foy = spread_value();
			p.fnx = spread_value();
			p.fny = spread_value();
		end else begin
			p.px = $urandom;
			p.py = $urandom;
			p.vx = $urandom;
			p.vy = $urandom;
			p.fox = $urandom;
			p.foy = $urandom;
			p.fnx = $urandom;
			p.fny = $urandom;
		end
		return p;
	endfunction

	// Present one item and hold it until accepted. Valid is left high on exit so
	// back-to-back items never lower and raise it in the same step.
	task automatic send_particle(input particle_in_t p);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= p.action;
		pos_x <= p.px;
		pos_y <= p.py;
		vel_x <= p.vx;
		vel_y <= p.vy;
		force_old_x <= p.fox;
		force_old_y <= p.foy;
		force_new_x <= p.fnx;
		force_new_y <= p.fny;
		last_particle <= p.last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Drop valid and hold off until every predicted item has come back.
	task automatic wait_all_returned();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (results_owed != 0);
	endtask

	// Write all three registers on consecutive cycles; call only while drained.
	task automatic write_config(input logic [15:0] dt, input logic [30:0] bw, bh);
		cfg_write <= 1'b1;
		cfg_index <= vvps_pkg::REG_TIME_STEP;
		cfg_data <= {15'd0, dt};
		@(posedge clk);
		cfg_index <= vvps_pkg::REG_BOX_WIDTH;
		cfg_data <= bw;
		@(posedge clk);
		cfg_index <= vvps_pkg::REG_BOX_HEIGHT;
		cfg_data <= bh;
		@(posedge clk);
		cfg_write <= 1'b0;
		box_w_now = bw;
		box_h_now = bh;
	endtask

	localparam logic signed [31:0] SMAX = 32'sh7fffffff;
	localparam logic signed [31:0] SMIN = 32'sh80000000;
	localparam logic signed [31:0] TEN  = 32'sd655360;	// 10.0, the reset box

	initial begin
		logic [15:0] dt;
		logic [30:0] bw, bh;

		// Hold reset, release it on an edge, then let the design settle.
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items under the reset configuration (dt = 328, box = 10.0).
		send_particle(make_particle(vvps_pkg::ACT_MOVE, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
		send_particle(make_particle(vvps_pkg::ACT_MOVE, SMAX, SMAX, SMAX, SMAX, SMAX,
			SMAX, SMIN, SMIN, 1'b1));
		send_particle(make_particle(vvps_pkg::ACT_MOVE, SMIN, SMIN, SMIN, SMIN, SMIN,
			SMIN, SMAX, SMAX, 1'b0));
		send_particle(make_particle(vvps_pkg::ACT_KICK, SMAX, SMIN, SMAX, SMAX, SMAX,
			SMAX, SMAX, SMAX, 1'b1));
		send_particle(make_particle(vvps_pkg::ACT_KICK, SMIN, SMAX, SMIN, SMIN, SMIN,
			SMIN, SMIN, SMIN, 1'b0));
		// wrap down past the high wall on x, up past the low wall on y
		send_particle(make_particle(vvps_pkg::ACT_MOVE, TEN - 1, 0, TEN, -TEN,
			0, 0, 0, 0, 1'b0));
		// wrap up on x, down on y
		send_particle(make_particle(vvps_pkg::ACT_MOVE, 0, TEN - 1, -TEN, TEN,
			0, 0, 0, 0, 1'b0));
		// sitting exactly on the box length: one subtraction lands on zero
		send_particle(make_particle(vvps_pkg::ACT_MOVE, TEN, TEN, 0, 0, 0, 0, 0, 0, 1'b1));
		// far outside the box: only one correction, result stays outside
		send_particle(make_particle(vvps_pkg::ACT_MOVE, 3 * TEN, -3 * TEN,
			0, 0, 0, 0, 0, 0, 1'b0));
		// force pushes across the wall on its own
		send_particle(make_particle(vvps_pkg::ACT_MOVE, TEN - 1, 1, 0, 0, SMAX, SMIN,
			0, 0, 1'b0));
		// rounding ties on v*dt, both signs
		send_particle(make_particle(vvps_pkg::ACT_MOVE, 32'sd65536, 32'sd65536,
			32'sd4096, -32'sd4096, 0, 0, 0, 0, 1'b0));
		// rounding ties on the velocity update, both signs
		send_particle(make_particle(vvps_pkg::ACT_KICK, 0, 0, 0, 0,
			32'sd335872, -32'sd335872, 0, 0, 1'b1));
		send_particle(make_particle(vvps_pkg::ACT_KICK, 0, 0, 32'sd7, -32'sd7,
			32'sd1, -32'sd1, 32'sd1, -32'sd2, 1'b0));
		// opposing forces cancel on x and sum to -1 on y; velocity must pass through
		send_particle(make_particle(vvps_pkg::ACT_KICK, 32'sd12345, -32'sd12345,
			SMAX, SMIN, SMAX, SMIN, -SMAX, 32'sh7fffffff, 1'b0));

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_all_returned();
			case (ph % 4)
				0: begin
					dt = 16'hffff;
					bw = 31'h7fffffff;
					bh = 31'h7fffffff;
				end
				1: begin
					dt = 16'd1;
					bw = 31'd1;
					bh = 31'd1;
				end
				2: begin
					dt = 16'($urandom_range(4096, 16));
					bw = 31'($urandom_range(1 << 24, 1 << 12));
					bh = 31'($urandom_range(1 << 24, 1 << 12));
				end
				default: begin
					dt = 16'($urandom_range(65535, 1));
					bw = 31'($urandom_range(32'h7fffffff, 1));
					bh = 31'($urandom_range(32'h7fffffff, 1));
				end
			endcase
			write_config(dt, bw, bh);
			case (ph / 2)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 75;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 75;
				end
				default: begin
					idle_pct = 18;
					stall_pct = 18;
				end
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				send_particle(random_particle());
				// now and then let the pipeline run dry mid-stream
				if ($urandom_range(199) == 0)
					wait_all_returned();
			end
		end

		// Drain, give the pipeline its latency plus margin, then judge.
		wait_all_returned();
		repeat (12) @(posedge clk);
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
